// ----- sv/conv3_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the 3x3 RGBA convolution unit.
// No dependencies.
package conv3_pkg;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int COEF_W     = 24;
    localparam int NORM_W     = 16;
    localparam int SIZE_W     = 12;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 32;
    localparam int POS_W      = 11;
    localparam int SUM_W      = 20;   // nine taps of signed 8b x unsigned 8b
    localparam int QUO_W      = 19;   // magnitude bits of a non-negative sum
    localparam int PROD_W     = 17;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd5;

    localparam logic [COEF_W-1:0] RST_COEF_TOP    = 24'h000000;
    localparam logic [COEF_W-1:0] RST_COEF_MID    = 24'h000100;
    localparam logic [COEF_W-1:0] RST_COEF_BOTTOM = 24'h000000;
    localparam logic [NORM_W-1:0] RST_NORM        = 16'd1;
    localparam logic [SIZE_W-1:0] RST_WIDTH       = 12'd640;
    localparam logic [SIZE_W-1:0] RST_HEIGHT      = 12'd480;
endpackage

// ----- sv/conv3_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port synchronous RAM, registered read, read-first.
// No dependencies.
module conv3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/conv3_div.sv -----
`timescale 1ns / 1ps
// Restoring divider for one channel sum; negative sums give 0, result clamped to 255.
// Depends on conv3_pkg.
module conv3_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [conv3_pkg::SUM_W-1:0]  i_sum,
    input  logic [conv3_pkg::NORM_W-1:0]        i_div,
    output logic                                o_done,
    output logic [conv3_pkg::CHAN_W-1:0]        o_quo
);
    localparam int QW    = conv3_pkg::QUO_W;
    localparam int DW    = conv3_pkg::NORM_W;
    localparam int CNT_W = $clog2(QW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [QW-1:0]    r_num;
    logic [DW:0]      r_rem;
    logic [DW:0]      rem_sh;
    logic [DW-1:0]    d_eff;
    logic             ge;

    always_comb begin
        d_eff  = (i_div == '0) ? DW'(1) : i_div;
        rem_sh = {r_rem[DW-1:0], r_num[QW-1]};
        ge     = (rem_sh >= {1'b0, d_eff});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_num  <= i_sum[conv3_pkg::SUM_W-1] ? '0 : i_sum[QW-1:0];
            end else if (r_busy) begin
                r_rem <= ge ? (rem_sh - {1'b0, d_eff}) : rem_sh;
                r_num <= {r_num[QW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (|r_num[QW-1:conv3_pkg::CHAN_W]) ? conv3_pkg::CHAN_MAX
                                                     : r_num[conv3_pkg::CHAN_W-1:0];
endmodule

// ----- sv/conv3x3_rgba_clamp_unit.sv -----
`timescale 1ns / 1ps
// 3x3 RGBA convolution with divide and clamp over a three-row pixel store.
// Depends on conv3_pkg, conv3_ram, conv3_div.
// Each result runs 9 store reads, a drain, a divider load,
// 19 divider steps (restoring, one bit a cycle), then output handoff, which waits while the output stalls.
// An item that causes no result leaves the unit idle; else the input stalls until its results (up to 4) are out.
// Reset clears counters and control and loads config registers with defaults; the pixel store is not cleared.
module conv3x3_rgba_clamp_unit #(
    parameter int MAX_WIDTH  = conv3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = conv3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [conv3_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [conv3_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [conv3_pkg::CHAN_W-1:0]        i_in_blue,
    input  logic [conv3_pkg::CHAN_W-1:0]        i_in_green,
    input  logic [conv3_pkg::CHAN_W-1:0]        i_in_red,
    input  logic [conv3_pkg::CHAN_W-1:0]        i_in_alpha,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [conv3_pkg::POS_W-1:0]         o_out_row,
    output logic [conv3_pkg::POS_W-1:0]         o_out_col,
    output logic [conv3_pkg::CHAN_W-1:0]        o_out_blue,
    output logic [conv3_pkg::CHAN_W-1:0]        o_out_green,
    output logic [conv3_pkg::CHAN_W-1:0]        o_out_red,
    output logic [conv3_pkg::CHAN_W-1:0]        o_out_alpha,
    output logic                                o_run_last
);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH  = 3 * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = conv3_pkg::CHAN_W;
    localparam int SW     = conv3_pkg::SUM_W;
    localparam int PW     = conv3_pkg::PROD_W;

    typedef enum logic [2:0] {S_IDLE, S_TAP, S_DRAIN, S_DIVS, S_DIVW, S_OUT} t_state;

    function automatic logic [1:0] m3_inc(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic logic [1:0] m3_dec(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

    t_state r_state;

    // configuration
    logic [conv3_pkg::COEF_W-1:0] r_coef_top, r_coef_mid, r_coef_bot;
    logic [conv3_pkg::NORM_W-1:0] r_norm;
    logic [conv3_pkg::SIZE_W-1:0] r_fw, r_fh;

    // position of the next pixel
    logic [WW-1:0] r_col;
    logic [HW-1:0] r_row;
    logic [1:0]    r_m3;

    // pixel just taken and its pending results
    logic [WW-1:0] r_cc;
    logic [HW-1:0] r_cr;
    logic [1:0]    r_cm;
    logic [3:0]    r_mask;

    logic [1:0]    r_z, r_w;
    logic          r_rd_vld;
    logic signed [CW-1:0] r_k;
    logic signed [SW-1:0] r_sum [4];

    logic          r_ovld;
    logic [conv3_pkg::POS_W-1:0] r_orow, r_ocol;
    logic [CW-1:0] r_och [4];
    logic          r_olast;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [WW-1:0] n_c, n_col;
    logic [HW-1:0] n_r, n_row;
    logic [1:0]    n_m, n_m3;
    logic [WW:0]   c_inc;
    logic [HW:0]   r_inc;
    logic [3:0]    n_mask;
    logic          accept;

    logic [1:0]    sel;
    logic [HW-1:0] pr;
    logic [WW-1:0] pc;
    logic [1:0]    pm;
    logic          oof;
    logic [1:0]    tm;
    logic [WW-1:0] tc;
    logic [CW-1:0] k_byte;
    logic [conv3_pkg::COEF_W-1:0] k_row;
    logic [AW-1:0] wr_addr, rd_addr, ram_addr;
    logic [conv3_pkg::PIX_W-1:0] rdata;
    logic [3:0]    lowbit;
    logic          one_left;
    logic          out_free;
    logic signed [PW-1:0] prod [4];
    logic [3:0]    div_done;
    logic [CW-1:0] quo [4];

    always_comb begin
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_fw) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_fh) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_fh);
        end
    end

    // wrap position before taking the pixel (covers a geometry change), then advance
    always_comb begin
        n_c = r_col;
        n_r = r_row;
        n_m = r_m3;
        if (n_c >= w_eff) begin
            n_c = '0;
            n_r = n_r + 1'b1;
            n_m = m3_inc(n_m);
        end
        if (n_r >= h_eff) begin
            n_r = '0;
            n_m = 2'd0;
        end
        c_inc = {1'b0, n_c} + 1'b1;
        r_inc = {1'b0, n_r} + 1'b1;
        n_col = n_c + 1'b1;
        n_row = n_r;
        n_m3  = n_m;
        if (c_inc >= {1'b0, w_eff}) begin
            n_col = '0;
            if (r_inc >= {1'b0, h_eff}) begin
                n_row = '0;
                n_m3  = 2'd0;
            end else begin
                n_row = HW'(r_inc);
                n_m3  = m3_inc(n_m);
            end
        end
        n_mask[0] = (n_r != '0) && (n_c != '0);
        n_mask[1] = (n_r != '0) && (c_inc == {1'b0, w_eff});
        n_mask[2] = (r_inc == {1'b0, h_eff}) && (n_c != '0);
        n_mask[3] = (r_inc == {1'b0, h_eff}) && (c_inc == {1'b0, w_eff});
        wr_addr = AW'(n_m) * AW'(MAX_WIDTH) + AW'(n_c);
    end

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);

    // current result: lowest pending bit; bit 1 of the slot picks row r, bit 0 column c
    always_comb begin
        if (r_mask[0]) begin
            sel = 2'd0;
        end else if (r_mask[1]) begin
            sel = 2'd1;
        end else if (r_mask[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        pr = sel[1] ? r_cr : r_cr - 1'b1;
        pc = sel[0] ? r_cc : r_cc - 1'b1;
        pm = sel[1] ? r_cm : m3_dec(r_cm);
        lowbit   = r_mask & (~r_mask + 4'd1);
        one_left = ((r_mask & (r_mask - 4'd1)) == 4'd0);

        oof = ((r_z == 2'd0) && (pr == '0))
           || ((r_z == 2'd2) && (({1'b0, pr} + 1'b1) >= {1'b0, h_eff}))
           || ((r_w == 2'd0) && (pc == '0))
           || ((r_w == 2'd2) && (({1'b0, pc} + 1'b1) >= {1'b0, w_eff}));
        if (oof) begin
            tm = pm;
            tc = pc;
        end else begin
            case (r_z)
                2'd0:    tm = m3_dec(pm);
                2'd2:    tm = m3_inc(pm);
                default: tm = pm;
            endcase
            tc = pc + WW'(r_w) - 1'b1;
        end
        rd_addr = AW'(tm) * AW'(MAX_WIDTH) + AW'(tc);

        case (r_z)
            2'd0:    k_row = r_coef_top;
            2'd1:    k_row = r_coef_mid;
            default: k_row = r_coef_bot;
        endcase
        case (r_w)
            2'd0:    k_byte = k_row[7:0];
            2'd1:    k_byte = k_row[15:8];
            default: k_byte = k_row[23:16];
        endcase
        ram_addr = accept ? wr_addr : rd_addr;
        out_free = !r_ovld || !i_out_stall;
    end

    conv3_ram #(
        .WIDTH (conv3_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_addr  (ram_addr),
        .i_wdata ({i_in_alpha, i_in_red, i_in_green, i_in_blue}),
        .o_rdata (rdata)
    );

    for (genvar g = 0; g < 4; g++) begin : g_ch
        assign prod[g] = PW'(r_k) * $signed({{(PW-CW){1'b0}}, rdata[g*CW +: CW]});

        conv3_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == S_DIVS),
            .i_sum   (r_sum[g]),
            .i_div   (r_norm),
            .o_done  (div_done[g]),
            .o_quo   (quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_coef_top <= conv3_pkg::RST_COEF_TOP;
            r_coef_mid <= conv3_pkg::RST_COEF_MID;
            r_coef_bot <= conv3_pkg::RST_COEF_BOTTOM;
            r_norm     <= conv3_pkg::RST_NORM;
            r_fw       <= conv3_pkg::RST_WIDTH;
            r_fh       <= conv3_pkg::RST_HEIGHT;
            r_col      <= '0;
            r_row      <= '0;
            r_m3       <= 2'd0;
            r_mask     <= 4'd0;
            r_rd_vld   <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    conv3_pkg::CFG_COEF_TOP:    r_coef_top <= i_cfg_data;
                    conv3_pkg::CFG_COEF_MID:    r_coef_mid <= i_cfg_data;
                    conv3_pkg::CFG_COEF_BOTTOM: r_coef_bot <= i_cfg_data;
                    conv3_pkg::CFG_NORM:        r_norm <= i_cfg_data[conv3_pkg::NORM_W-1:0];
                    conv3_pkg::CFG_WIDTH:       r_fw <= i_cfg_data[conv3_pkg::SIZE_W-1:0];
                    conv3_pkg::CFG_HEIGHT:      r_fh <= i_cfg_data[conv3_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end

            // a result loaded in S_OUT this cycle keeps the valid high
            if (r_ovld && !i_out_stall && !((r_state == S_OUT) && out_free)) begin
                r_ovld <= 1'b0;
            end

            // registered, so they line up with the read data in the cycle after the read address
            r_rd_vld <= (r_state == S_TAP);
            r_k      <= k_byte;
            if (r_rd_vld) begin
                for (int i = 0; i < 4; i++) begin
                    r_sum[i] <= r_sum[i] + SW'(prod[i]);
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_col  <= n_col;
                        r_row  <= n_row;
                        r_m3   <= n_m3;
                        r_cc   <= n_c;
                        r_cr   <= n_r;
                        r_cm   <= n_m;
                        r_mask <= n_mask;
                        r_z    <= 2'd0;
                        r_w    <= 2'd0;
                        if (n_mask != 4'd0) begin
                            r_state <= S_TAP;
                        end
                    end
                end
                S_TAP: begin
                    if ((r_z == 2'd0) && (r_w == 2'd0)) begin
                        for (int i = 0; i < 4; i++) begin
                            r_sum[i] <= '0;
                        end
                    end
                    if (r_w == 2'd2) begin
                        r_w <= 2'd0;
                        r_z <= r_z + 2'd1;
                        if (r_z == 2'd2) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_w <= r_w + 2'd1;
                    end
                end
                S_DRAIN: r_state <= S_DIVS;
                S_DIVS:  r_state <= S_DIVW;
                S_DIVW: begin
                    if (&div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovld  <= 1'b1;
                        r_orow  <= conv3_pkg::POS_W'(pr);
                        r_ocol  <= conv3_pkg::POS_W'(pc);
                        r_olast <= one_left;
                        for (int i = 0; i < 4; i++) begin
                            r_och[i] <= quo[i];
                        end
                        r_mask <= r_mask & ~lowbit;
                        r_z    <= 2'd0;
                        r_w    <= 2'd0;
                        r_state <= one_left ? S_IDLE : S_TAP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_out_blue  = r_och[0];
    assign o_out_green = r_och[1];
    assign o_out_red   = r_och[2];
    assign o_out_alpha = r_och[3];
    assign o_run_last  = r_olast;
endmodule
